[sv/ics_pkg.sv]
// ----------------------------------------------------------------------------
// ics_pkg: shared types and constants for the idlest CPU picker
// Record and result layouts, field widths and the saturation limit.
// ----------------------------------------------------------------------------
`default_nettype none

package ics_pkg;

  // Field widths
  localparam int unsigned CPU_W   = 3;
  localparam int unsigned LAT_W   = 32;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned LOAD_W  = 32;

  // Number of CPUs taking part in a scan; higher indexes are skipped
  localparam int unsigned MAX_CPUS = 8;

  // Largest latency or load kept after saturation
  localparam logic [LAT_W-1:0] SAT32 = 32'hFFFF_FFFE;

  // One per-CPU record
  typedef struct packed {
    logic [CPU_W-1:0]   cpu_index;
    logic [CPU_W-1:0]   home_cpu;
    logic               eligible;
    logic               is_idle;
    logic               has_idle_state;
    logic [LAT_W-1:0]   wake_lat;
    logic [STAMP_W-1:0] idle_ts;
    logic [LOAD_W-1:0]  cpu_load;
    logic               last;
  } rec_t;

  // One pick
  typedef struct packed {
    logic [CPU_W-1:0] chosen_cpu;
    logic             chosen_idle;
  } res_t;

endpackage

`default_nettype wire

[sv/ics_scan.sv]
// ----------------------------------------------------------------------------
// ics_scan: running-best tracker
// Compares one record against the idle and busy bests, updates them on take,
// and presents the pick that the scan would yield if this record closes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ics_scan (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire ics_pkg::rec_t rec,
  output ics_pkg::res_t      res
);
  import ics_pkg::*;

  logic [LAT_W-1:0]   best_latency_r, best_latency_nxt;
  logic [STAMP_W-1:0] best_stamp_r,   best_stamp_nxt;
  logic               idle_found_r,   idle_found_nxt;
  logic [CPU_W-1:0]   idle_pick_r,    idle_pick_nxt;
  logic [LOAD_W-1:0]  best_load_r,    best_load_nxt;
  logic               busy_found_r,   busy_found_nxt;
  logic [CPU_W-1:0]   busy_pick_r,    busy_pick_nxt;

  logic              in_range;
  logic              elig;
  logic [LAT_W-1:0]  lat_sat;
  logic [LOAD_W-1:0] load_sat;

  // Saturate latency and load so any real value beats the reset value
  assign lat_sat  = (rec.wake_lat == '1) ? SAT32 : rec.wake_lat;
  assign load_sat = (rec.cpu_load == '1) ? SAT32 : rec.cpu_load;
  assign in_range = (32'(rec.cpu_index) < MAX_CPUS);
  assign elig     = rec.eligible && in_range;

  // Compare the record against the running bests
  always_comb begin
    best_latency_nxt = best_latency_r;
    best_stamp_nxt   = best_stamp_r;
    idle_found_nxt   = idle_found_r;
    idle_pick_nxt    = idle_pick_r;
    best_load_nxt    = best_load_r;
    busy_found_nxt   = busy_found_r;
    busy_pick_nxt    = busy_pick_r;
    if (elig) begin
      if (rec.is_idle) begin
        if (rec.has_idle_state && (lat_sat < best_latency_r)) begin
          best_latency_nxt = lat_sat;
          best_stamp_nxt   = rec.idle_ts;
          idle_pick_nxt    = rec.cpu_index;
          idle_found_nxt   = 1'b1;
        end else if ((!rec.has_idle_state || (lat_sat == best_latency_r)) &&
                     (rec.idle_ts > best_stamp_r)) begin
          best_stamp_nxt = rec.idle_ts;
          idle_pick_nxt  = rec.cpu_index;
          idle_found_nxt = 1'b1;
        end
      end else begin
        if ((load_sat < best_load_r) ||
            ((load_sat == best_load_r) && (rec.cpu_index == rec.home_cpu))) begin
          best_load_nxt  = load_sat;
          busy_pick_nxt  = rec.cpu_index;
          busy_found_nxt = 1'b1;
        end
      end
    end
  end

  // Pick idle first, then least loaded, then home
  always_comb begin
    if (idle_found_nxt) begin
      res.chosen_cpu  = idle_pick_nxt;
      res.chosen_idle = 1'b1;
    end else begin
      res.chosen_cpu  = busy_found_nxt ? busy_pick_nxt : rec.home_cpu;
      res.chosen_idle = 1'b0;
    end
  end

  // Advance the bests; drop them after the closing record
  always_ff @(posedge clk) begin
    if (!rst_n || (take && rec.last)) begin
      best_latency_r <= '1;
      best_stamp_r   <= '0;
      idle_found_r   <= 1'b0;
      idle_pick_r    <= '0;
      best_load_r    <= '1;
      busy_found_r   <= 1'b0;
      busy_pick_r    <= '0;
    end else if (take) begin
      best_latency_r <= best_latency_nxt;
      best_stamp_r   <= best_stamp_nxt;
      idle_found_r   <= idle_found_nxt;
      idle_pick_r    <= idle_pick_nxt;
      best_load_r    <= best_load_nxt;
      busy_found_r   <= busy_found_nxt;
      busy_pick_r    <= busy_pick_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/idlest_cpu_select_top.sv]
// ----------------------------------------------------------------------------
// idlest_cpu_select_top: idlest CPU picker
// Takes one per-CPU record per request and returns one pick per scan.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | one per-CPU record
//  out_    | output    | out_valid/out_stall | chosen_cpu, chosen_idle
//
//  One record per cycle is accepted while in_stall is low; the pick shows on out_
//  once the record marked last has passed the input register, then the result register.
//  The compare against the running bests sits between those two registers.
//  Synchronous reset clears the scan state and both valid flags.
//  in_stall rises only while a closing record waits behind a stalled result.
// ----------------------------------------------------------------------------
`default_nettype none

module idlest_cpu_select_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ics_pkg::CPU_W-1:0]    in_cpu_index,
  input  wire logic [ics_pkg::CPU_W-1:0]    in_home_cpu,
  input  wire logic                         in_eligible,
  input  wire logic                         in_is_idle,
  input  wire logic                         in_has_idle_state,
  input  wire logic [ics_pkg::LAT_W-1:0]    in_wake_lat,
  input  wire logic [ics_pkg::STAMP_W-1:0]  in_idle_ts,
  input  wire logic [ics_pkg::LOAD_W-1:0]   in_cpu_load,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ics_pkg::CPU_W-1:0]         out_chosen_cpu,
  output logic                              out_chosen_idle
);
  import ics_pkg::*;

  logic s1_valid_r;
  rec_t s1_rec_r;
  logic s1_go;
  logic take;
  res_t pick;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  // Input stage moves on unless its closing record has no room downstream
  assign s1_go    = !s1_valid_r || !s1_rec_r.last || !out_valid_r || !out_stall;
  assign in_stall = !s1_go;
  assign take     = s1_valid_r && s1_go;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_go) begin
      s1_valid_r <= in_valid;
    end
    if (s1_go && in_valid) begin
      s1_rec_r.cpu_index      <= in_cpu_index;
      s1_rec_r.home_cpu       <= in_home_cpu;
      s1_rec_r.eligible       <= in_eligible;
      s1_rec_r.is_idle        <= in_is_idle;
      s1_rec_r.has_idle_state <= in_has_idle_state;
      s1_rec_r.wake_lat       <= in_wake_lat;
      s1_rec_r.idle_ts        <= in_idle_ts;
      s1_rec_r.cpu_load       <= in_cpu_load;
      s1_rec_r.last           <= in_last;
    end
  end

  ics_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .rec   (s1_rec_r),
    .res   (pick)
  );

  // Load the result on a closing record, drop it once taken
  always_comb begin
    if (take && s1_rec_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (take && s1_rec_r.last) begin
      out_res_r <= pick;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_cpu  = out_res_r.chosen_cpu;
  assign out_chosen_idle = out_res_r.chosen_idle;

endmodule

`default_nettype wire

[sv/ics_check.sv]
// ----------------------------------------------------------------------------
// ics_check: port-level checks for the idlest CPU picker
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module ics_check (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [ics_pkg::CPU_W-1:0] out_chosen_cpu,
  input wire logic                      out_chosen_idle
);

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result valid right after reset");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A stalled result holds its pick
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(out_valid && out_stall) && $past(rst_n)) |->
      (out_valid && $stable(out_chosen_cpu) && $stable(out_chosen_idle)))
    else $error("stalled result changed");

  // A result leaves only when taken
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(out_valid) && $past(rst_n)) |-> $past(!out_stall))
    else $error("result dropped without being taken");

endmodule

bind idlest_cpu_select_top ics_check u_ics_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_chosen_cpu  (out_chosen_cpu),
  .out_chosen_idle (out_chosen_idle)
);

`default_nettype wire

[tb/idlest_cpu_select_chk.sv]
// ----------------------------------------------------------------------------
// idlest_cpu_select_chk: scoreboard for the idlest CPU picker
// Watches both channels. It keeps its own copy of the running bests of a scan
// and queues the pick that each closing record should produce. Every pick
// that leaves the block is compared field by field with the oldest queued
// pick. It reports the number of picks still due and the number of failures.
// ----------------------------------------------------------------------------
module idlest_cpu_select_chk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [ics_pkg::CPU_W-1:0]   in_cpu_index,
  input  logic [ics_pkg::CPU_W-1:0]   in_home_cpu,
  input  logic                        in_eligible,
  input  logic                        in_is_idle,
  input  logic                        in_has_idle_state,
  input  logic [ics_pkg::LAT_W-1:0]   in_wake_lat,
  input  logic [ics_pkg::STAMP_W-1:0] in_idle_ts,
  input  logic [ics_pkg::LOAD_W-1:0]  in_cpu_load,
  input  logic                        in_last,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [ics_pkg::CPU_W-1:0]   out_chosen_cpu,
  input  logic                        out_chosen_idle,
  output int                          pending,
  output int                          fail_count
);
  import ics_pkg::*;

  // Running bests of the scan in progress
  logic [LAT_W-1:0]   best_lat;
  logic [STAMP_W-1:0] best_stamp;
  logic               idle_seen;
  logic [CPU_W-1:0]   idle_win;
  logic [LOAD_W-1:0]  best_load;
  logic               busy_seen;
  logic [CPU_W-1:0]   busy_cpu;

  // Picks owed by closed scans, oldest first
  res_t pick_q[$];
  int   n_fail = 0;

  // Clamp an all-ones latency or load to the saturation limit
  function automatic logic [31:0] clamp_sat(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? SAT32 : v;
  endfunction

  function automatic void clear_scan();
    best_lat   = '1;
    best_stamp = '0;
    idle_seen  = 1'b0;
    idle_win   = '0;
    best_load  = '1;
    busy_seen  = 1'b0;
    busy_cpu   = '0;
  endfunction

  // Fold one record into the running bests; close the scan on the last one
  function automatic void absorb_record(input rec_t r);
    logic [LAT_W-1:0]  lat;
    logic [LOAD_W-1:0] load;
    res_t              pick;
    lat  = clamp_sat(r.wake_lat);
    load = clamp_sat(r.cpu_load);
    if (r.eligible && 32'(r.cpu_index) < MAX_CPUS) begin
      if (r.is_idle) begin
        if (r.has_idle_state && lat < best_lat) begin
          best_lat   = lat;
          best_stamp = r.idle_ts;
          idle_win   = r.cpu_index;
          idle_seen  = 1'b1;
        end else if ((!r.has_idle_state || lat == best_lat) &&
                     r.idle_ts > best_stamp) begin
          // equal latency or no idle state: only a newer stamp wins
          best_stamp = r.idle_ts;
          idle_win   = r.cpu_index;
          idle_seen  = 1'b1;
        end
      end else if (load < best_load ||
                   (load == best_load && r.cpu_index == r.home_cpu)) begin
        best_load = load;
        busy_cpu  = r.cpu_index;
        busy_seen = 1'b1;
      end
    end
    if (r.last) begin
      if (idle_seen) begin
        pick.chosen_cpu  = idle_win;
        pick.chosen_idle = 1'b1;
      end else begin
        // fall back to the home CPU of the closing record
        pick.chosen_cpu  = busy_seen ? busy_cpu : r.home_cpu;
        pick.chosen_idle = 1'b0;
      end
      pick_q.push_back(pick);
      clear_scan();
    end
  endfunction

  function automatic void report(string field, int want, int got);
    if (n_fail < 10) begin
      $display("ERROR: %s expected %0d got %0d at %0t", field, want, got, $time);
    end
    n_fail++;
  endfunction

  // Compare picks first, then absorb the request taken at the same edge
  always @(posedge clk) begin : watch
    rec_t r;
    res_t want;
    if (!rst_n) begin
      clear_scan();
      pick_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pick_q.size() == 0) begin
          if (n_fail < 10) begin
            $display("ERROR: pick cpu %0d idle %0d with no scan closed at %0t",
                     out_chosen_cpu, out_chosen_idle, $time);
          end
          n_fail++;
        end else begin
          want = pick_q.pop_front();
          if (out_chosen_cpu !== want.chosen_cpu) begin
            report("chosen_cpu", int'(want.chosen_cpu), int'(out_chosen_cpu));
          end
          if (out_chosen_idle !== want.chosen_idle) begin
            report("chosen_idle", int'(want.chosen_idle), int'(out_chosen_idle));
          end
        end
      end
      if (in_valid && !in_stall) begin
        r.cpu_index      = in_cpu_index;
        r.home_cpu       = in_home_cpu;
        r.eligible       = in_eligible;
        r.is_idle        = in_is_idle;
        r.has_idle_state = in_has_idle_state;
        r.wake_lat       = in_wake_lat;
        r.idle_ts        = in_idle_ts;
        r.cpu_load       = in_cpu_load;
        r.last           = in_last;
        absorb_record(r);
      end
    end
    pending    <= pick_q.size();
    fail_count <= n_fail;
  end

endmodule

[tb/tb_idlest_cpu_select_top.sv]
// ----------------------------------------------------------------------------
// tb_idlest_cpu_select_top: testbench for the idlest CPU picker
// Sends directed scans over the corner cases and then about 550 random
// records. The records are grouped mostly in well-formed scans, with some
// noise scans mixed in. Both sides idle at random. The receiver holds off
// once for a long stretch. A side checker predicts and compares each pick.
// ----------------------------------------------------------------------------
module tb_idlest_cpu_select_top;
  import ics_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  rec_t             in_rec;
  logic             out_valid;
  logic             out_stall;
  logic [CPU_W-1:0] out_chosen_cpu;
  logic             out_chosen_idle;
  int               chk_pending;
  int               chk_fail;

  // Sender state shared by the stimulus tasks
  bit gaps_on;
  int n_sent;

  idlest_cpu_select_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cpu_index      (in_rec.cpu_index),
    .in_home_cpu       (in_rec.home_cpu),
    .in_eligible       (in_rec.eligible),
    .in_is_idle        (in_rec.is_idle),
    .in_has_idle_state (in_rec.has_idle_state),
    .in_wake_lat       (in_rec.wake_lat),
    .in_idle_ts        (in_rec.idle_ts),
    .in_cpu_load       (in_rec.cpu_load),
    .in_last           (in_rec.last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_chosen_cpu    (out_chosen_cpu),
    .out_chosen_idle   (out_chosen_idle)
  );

  idlest_cpu_select_chk u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cpu_index      (in_rec.cpu_index),
    .in_home_cpu       (in_rec.home_cpu),
    .in_eligible       (in_rec.eligible),
    .in_is_idle        (in_rec.is_idle),
    .in_has_idle_state (in_rec.has_idle_state),
    .in_wake_lat       (in_rec.wake_lat),
    .in_idle_ts        (in_rec.idle_ts),
    .in_cpu_load       (in_rec.cpu_load),
    .in_last           (in_rec.last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_chosen_cpu    (out_chosen_cpu),
    .out_chosen_idle   (out_chosen_idle),
    .pending           (chk_pending),
    .fail_count        (chk_fail)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Latency or load: favor extremes and small values so ties happen
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return SAT32;
      3, 4:    return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_stamp();
    case ($urandom_range(0, 4))
      0:       return 64'd0;
      1:       return '1;
      2, 3:    return 64'($urandom_range(0, 3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one record at a falling edge and hold it until the block takes it
  task automatic send_record(input int cpu, input int home,
                             input int elig, input int idle, input int hs,
                             input logic [31:0] lat, input logic [63:0] stamp,
                             input logic [31:0] load, input int last);
    rec_t r;
    r.cpu_index      = CPU_W'(cpu);
    r.home_cpu       = CPU_W'(home);
    r.eligible       = 1'(elig);
    r.is_idle        = 1'(idle);
    r.has_idle_state = 1'(hs);
    r.wake_lat       = lat;
    r.idle_ts        = stamp;
    r.cpu_load       = load;
    r.last           = 1'(last);
    while (gaps_on && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rec   <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    n_sent++;
  endtask

  // Drop valid and hold until every owed pick has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (chk_pending != 0);
  endtask

  // Receiver: random stalls, one long hold-off, one stretch without stalls
  initial begin : recv
    int cyc;
    cyc = 0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 150 && cyc < 230) begin
        out_stall <= 1'b1;
      end else if (cyc >= 450 && cyc < 650) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 18);
      end
    end
  end

  initial begin : stim
    int         len;
    bit         noise;
    bit         paused;
    int         home;
    rst_n   = 1'b0;
    in_valid = 1'b0;
    in_rec  = '0;
    gaps_on = 1'b1;
    n_sent  = 0;
    paused  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Idle group: saturated latency, equal latency with newer stamp,
    // lower latency, no idle state with newer stamp, ineligible closer
    send_record(0, 5, 1, 1, 1, 32'hFFFF_FFFF, 64'd0, 32'd0, 0);
    send_record(7, 5, 1, 1, 1, SAT32, '1, 32'hFFFF_FFFF, 0);
    send_record(3, 5, 1, 1, 1, 32'd0, 64'd1, 32'd0, 0);
    send_record(2, 5, 1, 1, 0, 32'd0, 64'd2, 32'd0, 0);
    send_record(4, 5, 0, 1, 1, 32'd0, '1, 32'd0, 1);
    // Busy group: saturated load, load tie on home, home changing mid-scan
    send_record(1, 6, 1, 0, 1, 32'd0, '1, 32'hFFFF_FFFF, 0);
    send_record(6, 6, 1, 0, 0, 32'd0, 64'd0, SAT32, 0);
    send_record(0, 6, 1, 0, 0, 32'd5, 64'd0, 32'd0, 0);
    send_record(5, 5, 1, 0, 0, 32'd0, 64'd0, 32'd0, 0);
    send_record(3, 6, 1, 0, 0, 32'd0, 64'd0, 32'd0, 1);
    // Nothing eligible: default to the home CPU of the closing record
    send_record(2, 4, 0, 0, 0, 32'd0, 64'd0, 32'd0, 0);
    send_record(1, 3, 0, 1, 1, 32'd0, '1, 32'd0, 1);
    // Idle CPU without idle state and a zero stamp never wins
    send_record(4, 7, 1, 1, 0, 32'd0, 64'd0, 32'd0, 1);
    // Idle pick beats busy pick; equal or older stamps keep the first
    send_record(1, 0, 1, 0, 0, 32'd0, 64'd0, 32'd10, 0);
    send_record(2, 0, 1, 1, 1, 32'd100, 64'd50, 32'd0, 0);
    send_record(3, 0, 1, 1, 1, 32'd100, 64'd50, 32'd0, 0);
    send_record(4, 0, 1, 1, 1, 32'd100, 64'd40, 32'd0, 1);
    // Higher latency with newer stamp loses
    send_record(6, 2, 1, 1, 1, 32'd5, 64'd10, 32'd0, 0);
    send_record(0, 2, 1, 1, 1, 32'd6, 64'd99, 32'd0, 1);
    // Back-to-back single-record scans
    send_record(0, 0, 1, 0, 0, 32'd0, 64'd0, 32'd0, 1);
    send_record(7, 1, 1, 1, 1, 32'd0, 64'd0, 32'd0, 1);
    wait_drained();

    // Random scans: mostly well-formed, some noise with stray closers
    n_sent = 0;
    while (n_sent < 550) begin
      noise = ($urandom_range(0, 9) == 0);
      len   = $urandom_range(1, 8);
      home  = $urandom_range(0, 7);
      for (int k = 0; k < len; k++) begin
        gaps_on = !(n_sent >= 350 && n_sent < 450);
        if (noise) begin
          send_record($urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom, {$urandom, $urandom},
                      $urandom, int'($urandom_range(0, 3) == 0));
        end else begin
          if ($urandom_range(0, 19) == 0) home = $urandom_range(0, 7);
          send_record($urandom_range(0, 7), home,
                      int'($urandom_range(0, 99) < 85),
                      $urandom_range(0, 1), int'($urandom_range(0, 4) != 0),
                      pick_word(), pick_stamp(), pick_word(),
                      int'(k == len - 1));
        end
      end
      if (!paused && n_sent >= 300) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    // Drain, then give the pipeline time to show any stray pick
    in_valid <= 1'b0;
    for (int w = 0; w < 5000 && chk_pending != 0; w++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (chk_fail == 0 && chk_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin : watchdog
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
